FILE: design/alr_pkg.sv
// ----------------------------------------------------------------------------
// alr_pkg: shared types and constants of the angle-guided line rasterizer
// Holds the transaction structs, the sequencer states, the CORDIC angle
// table and the direction table of the eight grid neighbours.
// ----------------------------------------------------------------------------
package alr_pkg;

    localparam int COORD_W      = 12;
    localparam int MAG_W        = COORD_W + 1;
    localparam int PRE_SHIFT    = 24;
    localparam int CW           = MAG_W + PRE_SHIFT + 3;
    localparam int CORDIC_STEPS = 20;
    localparam int STEP_W       = 5;
    localparam int ANG_SCALE    = 20;
    localparam int ZW           = 29;
    localparam int DEG_W        = 9;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [2:0] octant_t;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    typedef struct packed {
        logic   operation;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } req_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        logic   last;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_POST,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MODE_REF,
        MODE_CAND0,
        MODE_CAND1
    } mode_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            5'd0:    v = ZW'(47185920);
            5'd1:    v = ZW'(27855475);
            5'd2:    v = ZW'(14718068);
            5'd3:    v = ZW'(7471121);
            5'd4:    v = ZW'(3750058);
            5'd5:    v = ZW'(1876857);
            5'd6:    v = ZW'(938658);
            5'd7:    v = ZW'(469357);
            5'd8:    v = ZW'(234682);
            5'd9:    v = ZW'(117342);
            5'd10:   v = ZW'(58671);
            5'd11:   v = ZW'(29335);
            5'd12:   v = ZW'(14668);
            5'd13:   v = ZW'(7334);
            5'd14:   v = ZW'(3667);
            5'd15:   v = ZW'(1833);
            5'd16:   v = ZW'(917);
            5'd17:   v = ZW'(458);
            5'd18:   v = ZW'(229);
            5'd19:   v = ZW'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic coord_t step_dx(input octant_t o);
        coord_t v;
        unique case (o)
            3'd0, 3'd1, 3'd7: v = coord_t'(1);
            3'd2, 3'd6:       v = '0;
            default:          v = '1;
        endcase
        return v;
    endfunction

    function automatic coord_t step_dy(input octant_t o);
        coord_t v;
        unique case (o)
            3'd1, 3'd2, 3'd3: v = coord_t'(1);
            3'd0, 3'd4:       v = '0;
            default:          v = '1;
        endcase
        return v;
    endfunction

endpackage

FILE: design/angle_guided_line_rasterizer.sv
// ----------------------------------------------------------------------------
// angle_guided_line_rasterizer: grid line stepping guided by direction angles
// One request transaction gives exactly one response transaction.
// ----------------------------------------------------------------------------
// Usage: a request with operation start loads both endpoints and answers
// with the start point; each advance request answers with the next grid
// point, and the end point comes with last set. Advances after the end
// repeat the end point with last set.
// Both channels use valid and stall. The block raises req_stall from the
// cycle after a request is taken until its response has been taken.
// A start needs one CORDIC pass and an advance two passes through the
// shared CORDIC iteration unit, each followed by a post-processing step;
// trivial cases (finished line, end point reached) skip the CORDIC and
// answer directly.
// The response sits in an output register; while rsp_stall is high it
// holds, and no new request is taken.
// Reset clears the current and target points to the origin and marks the
// line as finished.
// ----------------------------------------------------------------------------
module angle_guided_line_rasterizer #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  alr_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output alr_pkg::rsp_t rsp
);

    localparam int RW     = alr_pkg::DEG_W + ANGLE_FRAC_BITS;
    localparam int RSHIFT = alr_pkg::ANG_SCALE - ANGLE_FRAC_BITS;
    localparam int FW     = alr_pkg::ZW;

    alr_pkg::state_t state_reg, state_next;
    alr_pkg::mode_t  mode_reg, mode_next;
    alr_pkg::coord_t cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    alr_pkg::coord_t tgt_x_reg, tgt_x_next, tgt_y_reg, tgt_y_next;
    alr_pkg::coord_t cb_x_reg, cb_x_next, cb_y_reg, cb_y_next;
    logic [RW-1:0]   ref_reg, ref_next;
    alr_pkg::octant_t oct_reg, oct_next;
    logic            fin_reg, fin_next;
    alr_pkg::rsp_t   out_reg, out_next;
    logic signed [alr_pkg::CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [alr_pkg::ZW-1:0] z_reg, z_next;
    logic [alr_pkg::STEP_W-1:0]    cnt_reg, cnt_next;
    logic            nx_reg, nx_next, ny_reg, ny_next;
    logic [alr_pkg::DEG_W-1:0]     a0_reg, a0_next;

    alr_pkg::coord_t ca_x, ca_y, cbx, cby;
    logic            hit;
    logic            start_eq;
    logic            need_cordic;
    logic            ld;
    alr_pkg::coord_t ld_tx, ld_ty, ld_px, ld_py;
    logic signed [alr_pkg::MAG_W-1:0] dfx, dfy;
    logic [alr_pkg::MAG_W-1:0]        mgx, mgy;
    logic signed [alr_pkg::CW-1:0]    xs, ys;
    logic [FW-1:0]    t_clamp, full;
    logic [FW:0]      full_rnd;
    logic [RW-1:0]    ref_calc;
    alr_pkg::octant_t oct_calc;
    logic [alr_pkg::DEG_W-1:0] a_deg;
    logic signed [RW+1:0] e0, e1;
    logic [RW+1:0]        e0a, e1a;

    always_comb
    begin
        ca_x = cur_x_reg + alr_pkg::step_dx(oct_reg);
        ca_y = cur_y_reg + alr_pkg::step_dy(oct_reg);
        cbx  = cur_x_reg + alr_pkg::step_dx(oct_reg + 3'd1);
        cby  = cur_y_reg + alr_pkg::step_dy(oct_reg + 3'd1);
        hit  = (ca_x == tgt_x_reg && ca_y == tgt_y_reg)
            || (cbx == tgt_x_reg && cby == tgt_y_reg);
        start_eq = (req.start_x == req.end_x) && (req.start_y == req.end_y);
        if (req.operation == alr_pkg::OP_START)
        begin
            need_cordic = !start_eq;
        end
        else
        begin
            need_cordic = !fin_reg && !hit;
        end
    end

    always_comb
    begin
        t_clamp = z_reg[alr_pkg::ZW-1] ? '0
                : (z_reg > alr_pkg::ZW'(90 << alr_pkg::ANG_SCALE))
                  ? FW'(90 << alr_pkg::ANG_SCALE) : FW'(z_reg);
        priority if (!nx_reg && !ny_reg)
        begin
            full = t_clamp;
        end
        else if (nx_reg && !ny_reg)
        begin
            full = FW'(180 << alr_pkg::ANG_SCALE) - t_clamp;
        end
        else if (nx_reg)
        begin
            full = FW'(180 << alr_pkg::ANG_SCALE) + t_clamp;
        end
        else
        begin
            full = FW'(360 << alr_pkg::ANG_SCALE) - t_clamp;
        end
        full_rnd = {1'b0, full} + (FW+1)'(1 << (RSHIFT - 1));
        ref_calc = RW'(full_rnd >> RSHIFT);
        oct_calc = '0;
        for (int k = 1; k < 8; k++)
        begin
            if (ref_calc >= RW'((45 * k) << ANGLE_FRAC_BITS))
            begin
                oct_calc = alr_pkg::octant_t'(k);
            end
        end
        if (ref_calc >= RW'(360 << ANGLE_FRAC_BITS))
        begin
            oct_calc = '0;
        end
        a_deg = alr_pkg::DEG_W'(full >> alr_pkg::ANG_SCALE);
        e0  = $signed({2'b00, ref_reg}) - $signed({2'b00, a0_reg, {ANGLE_FRAC_BITS{1'b0}}});
        e1  = $signed({2'b00, ref_reg}) - $signed({2'b00, a_deg, {ANGLE_FRAC_BITS{1'b0}}});
        e0a = e0[RW+1] ? (RW+2)'(-e0) : (RW+2)'(e0);
        e1a = e1[RW+1] ? (RW+2)'(-e1) : (RW+2)'(e1);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            alr_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = need_cordic ? alr_pkg::ST_CORDIC : alr_pkg::ST_OUT;
                end
            end
            alr_pkg::ST_CORDIC:
            begin
                if (cnt_reg == alr_pkg::STEP_W'(alr_pkg::CORDIC_STEPS - 1))
                begin
                    state_next = alr_pkg::ST_POST;
                end
            end
            alr_pkg::ST_POST:
            begin
                state_next = (mode_reg == alr_pkg::MODE_CAND0)
                           ? alr_pkg::ST_CORDIC : alr_pkg::ST_OUT;
            end
            alr_pkg::ST_OUT:
            begin
                if (!rsp_stall)
                begin
                    state_next = alr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = alr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = (state_reg != alr_pkg::ST_IDLE);
        rsp_valid = (state_reg == alr_pkg::ST_OUT);
        rsp       = out_reg;
    end

    always_comb
    begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        tgt_x_next = tgt_x_reg;
        tgt_y_next = tgt_y_reg;
        cb_x_next  = cb_x_reg;
        cb_y_next  = cb_y_reg;
        ref_next   = ref_reg;
        oct_next   = oct_reg;
        fin_next   = fin_reg;
        out_next   = out_reg;
        mode_next  = mode_reg;
        a0_next    = a0_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        cnt_next   = cnt_reg;
        nx_next    = nx_reg;
        ny_next    = ny_reg;
        ld         = 1'b0;
        ld_tx      = tgt_x_reg;
        ld_ty      = tgt_y_reg;
        ld_px      = cb_x_reg;
        ld_py      = cb_y_reg;
        xs         = x_reg >>> cnt_reg;
        ys         = y_reg >>> cnt_reg;
        unique case (state_reg)
            alr_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.operation == alr_pkg::OP_START)
                    begin
                        cur_x_next = req.start_x;
                        cur_y_next = req.start_y;
                        tgt_x_next = req.end_x;
                        tgt_y_next = req.end_y;
                        if (start_eq)
                        begin
                            ref_next = '0;
                            oct_next = '0;
                            fin_next = 1'b1;
                            out_next = '{req.start_x, req.start_y, 1'b1};
                        end
                        else
                        begin
                            ld        = 1'b1;
                            ld_tx     = req.end_x;
                            ld_ty     = req.end_y;
                            ld_px     = req.start_x;
                            ld_py     = req.start_y;
                            mode_next = alr_pkg::MODE_REF;
                        end
                    end
                    else if (fin_reg)
                    begin
                        out_next = '{tgt_x_reg, tgt_y_reg, 1'b1};
                    end
                    else if (hit)
                    begin
                        cur_x_next = tgt_x_reg;
                        cur_y_next = tgt_y_reg;
                        fin_next   = 1'b1;
                        out_next   = '{tgt_x_reg, tgt_y_reg, 1'b1};
                    end
                    else
                    begin
                        cur_x_next = ca_x;
                        cur_y_next = ca_y;
                        cb_x_next  = cbx;
                        cb_y_next  = cby;
                        ld         = 1'b1;
                        ld_px      = ca_x;
                        ld_py      = ca_y;
                        mode_next  = alr_pkg::MODE_CAND0;
                    end
                end
            end
            alr_pkg::ST_CORDIC:
            begin
                if (y_reg > 0)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + alr_pkg::atan_entry(cnt_reg);
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - alr_pkg::atan_entry(cnt_reg);
                end
                cnt_next = cnt_reg + 1'b1;
            end
            alr_pkg::ST_POST:
            begin
                unique case (mode_reg)
                    alr_pkg::MODE_REF:
                    begin
                        ref_next = ref_calc;
                        oct_next = oct_calc;
                        fin_next = 1'b0;
                        out_next = '{cur_x_reg, cur_y_reg, 1'b0};
                    end
                    alr_pkg::MODE_CAND0:
                    begin
                        a0_next   = a_deg;
                        ld        = 1'b1;
                        mode_next = alr_pkg::MODE_CAND1;
                    end
                    default:
                    begin
                        if (e0a > e1a)
                        begin
                            cur_x_next = cb_x_reg;
                            cur_y_next = cb_y_reg;
                            out_next   = '{cb_x_reg, cb_y_reg, 1'b0};
                        end
                        else
                        begin
                            out_next = '{cur_x_reg, cur_y_reg, 1'b0};
                        end
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        dfx = {ld_tx[alr_pkg::COORD_W-1], ld_tx} - {ld_px[alr_pkg::COORD_W-1], ld_px};
        dfy = {ld_ty[alr_pkg::COORD_W-1], ld_ty} - {ld_py[alr_pkg::COORD_W-1], ld_py};
        mgx = dfx[alr_pkg::MAG_W-1] ? alr_pkg::MAG_W'(-dfx) : alr_pkg::MAG_W'(dfx);
        mgy = dfy[alr_pkg::MAG_W-1] ? alr_pkg::MAG_W'(-dfy) : alr_pkg::MAG_W'(dfy);
        if (ld)
        begin
            x_next   = {3'b000, mgx, {alr_pkg::PRE_SHIFT{1'b0}}};
            y_next   = {3'b000, mgy, {alr_pkg::PRE_SHIFT{1'b0}}};
            z_next   = '0;
            cnt_next = '0;
            nx_next  = dfx[alr_pkg::MAG_W-1];
            ny_next  = dfy[alr_pkg::MAG_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= alr_pkg::ST_IDLE;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            tgt_x_reg <= '0;
            tgt_y_reg <= '0;
            ref_reg   <= '0;
            oct_reg   <= '0;
            fin_reg   <= 1'b1;
            mode_reg  <= alr_pkg::MODE_REF;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            tgt_x_reg <= tgt_x_next;
            tgt_y_reg <= tgt_y_next;
            ref_reg   <= ref_next;
            oct_reg   <= oct_next;
            fin_reg   <= fin_next;
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cb_x_reg <= cb_x_next;
        cb_y_reg <= cb_y_next;
        out_reg  <= out_next;
        a0_reg   <= a0_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        nx_reg   <= nx_next;
        ny_reg   <= ny_next;
    end

endmodule

FILE: test/alr_checker.sv
// ----------------------------------------------------------------------------
// alr_checker: response checker of the angle-guided line rasterizer
// Watches both channels, predicts each response from the accepted requests
// with its own line stepping model and compares responses field by field.
// ----------------------------------------------------------------------------
module alr_checker #(
    parameter int FRAC = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_stall,
    input  alr_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  alr_pkg::rsp_t rsp,
    output int            errors,
    output int            pending,
    output int            points_seen,
    output int            lines_done
);

    localparam longint QUARTER = longint'(90) <<< 20;
    localparam longint HALF = longint'(180) <<< 20;

    alr_pkg::coord_t cur_x, cur_y, tgt_x, tgt_y;
    longint ref_ang;
    alr_pkg::octant_t oct;
    logic done;
    alr_pkg::rsp_t point_queue[$];

    function automatic longint cordic_step_angle(input int i);
        longint tab[20] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
                            938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334,
                            3667, 1833, 917, 458, 229, 115};
        return tab[i];
    endfunction

    function automatic longint direction_angle(input longint dx, input longint dy);
        longint x, y, z, t, xs, ys;
        x = (dx < 0 ? -dx : dx) <<< 24;
        y = (dy < 0 ? -dy : dy) <<< 24;
        z = 0;
        for (int i = 0; i < 20; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys;
                y -= xs;
                z += cordic_step_angle(i);
            end
            else
            begin
                x -= ys;
                y += xs;
                z -= cordic_step_angle(i);
            end
        end
        t = z < 0 ? 0 : (z > QUARTER ? QUARTER : z);
        if (dx >= 0 && dy >= 0) return t;
        if (dx < 0 && dy >= 0) return HALF - t;
        if (dx < 0) return HALF + t;
        return 2 * HALF - t;
    endfunction

    function automatic alr_pkg::coord_t move(input alr_pkg::coord_t c, input int d);
        return alr_pkg::coord_t'(c + d);
    endfunction

    task automatic predict_point(input alr_pkg::req_t r);
        alr_pkg::rsp_t p;
        alr_pkg::octant_t d0, d1;
        alr_pkg::coord_t ax, ay, bx, by;
        longint a0, a1, e0, e1;
        int dxt[8] = '{1, 1, 0, -1, -1, -1, 0, 1};
        int dyt[8] = '{0, 1, 1, 1, 0, -1, -1, -1};
        if (r.operation == alr_pkg::OP_START)
        begin
            cur_x = r.start_x;
            cur_y = r.start_y;
            tgt_x = r.end_x;
            tgt_y = r.end_y;
            if (cur_x == tgt_x && cur_y == tgt_y)
            begin
                ref_ang = 0;
                oct = '0;
                done = 1'b1;
                p = '{cur_x, cur_y, 1'b1};
            end
            else
            begin
                a0 = direction_angle(longint'(tgt_x) - cur_x, longint'(tgt_y) - cur_y);
                ref_ang = (a0 + (longint'(1) <<< (20 - FRAC - 1))) >>> (20 - FRAC);
                oct = alr_pkg::octant_t'(ref_ang / (longint'(45) <<< FRAC));
                done = 1'b0;
                p = '{cur_x, cur_y, 1'b0};
            end
        end
        else if (done)
        begin
            p = '{tgt_x, tgt_y, 1'b1};
        end
        else
        begin
            d0 = oct;
            d1 = oct + 3'd1;
            ax = move(cur_x, dxt[d0]);
            ay = move(cur_y, dyt[d0]);
            bx = move(cur_x, dxt[d1]);
            by = move(cur_y, dyt[d1]);
            if ((ax == tgt_x && ay == tgt_y) || (bx == tgt_x && by == tgt_y))
            begin
                cur_x = tgt_x;
                cur_y = tgt_y;
                done = 1'b1;
                p = '{tgt_x, tgt_y, 1'b1};
            end
            else
            begin
                a0 = direction_angle(longint'(tgt_x) - ax, longint'(tgt_y) - ay) >>> 20;
                a1 = direction_angle(longint'(tgt_x) - bx, longint'(tgt_y) - by) >>> 20;
                e0 = ref_ang - (a0 <<< FRAC);
                e1 = ref_ang - (a1 <<< FRAC);
                if (e0 < 0) e0 = -e0;
                if (e1 < 0) e1 = -e1;
                if (e0 <= e1)
                begin
                    cur_x = ax;
                    cur_y = ay;
                end
                else
                begin
                    cur_x = bx;
                    cur_y = by;
                end
                p = '{cur_x, cur_y, 1'b0};
            end
        end
        point_queue.insert(point_queue.size(), p);
    endtask

    assign pending = point_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        alr_pkg::rsp_t want;
        if (!rst_n)
        begin
            cur_x = '0;
            cur_y = '0;
            tgt_x = '0;
            tgt_y = '0;
            ref_ang = 0;
            oct = '0;
            done = 1'b1;
            errors = 0;
            points_seen = 0;
            lines_done = 0;
            point_queue.delete();
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                points_seen++;
                if (rsp.last) lines_done++;
                if (point_queue.size() == 0)
                begin
                    $error("unexpected response x=%0d y=%0d last=%0b",
                           rsp.point_x, rsp.point_y, rsp.last);
                    errors++;
                end
                else
                begin
                    want = point_queue.pop_front();
                    if (rsp.point_x !== want.point_x)
                    begin
                        $error("point_x expected %0d actual %0d", want.point_x, rsp.point_x);
                        errors++;
                    end
                    if (rsp.point_y !== want.point_y)
                    begin
                        $error("point_y expected %0d actual %0d", want.point_y, rsp.point_y);
                        errors++;
                    end
                    if (rsp.last !== want.last)
                    begin
                        $error("last expected %0b actual %0b", want.last, rsp.last);
                        errors++;
                    end
                end
            end
            if (req_valid && !req_stall) predict_point(req);
        end
    end

endmodule

FILE: test/angle_guided_line_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// angle_guided_line_rasterizer_tb: regression of the line rasterizer
// Drives directed and random line requests with bursty requests and a
// stalling receiver; a checker predicts and compares every response.
// ----------------------------------------------------------------------------
module angle_guided_line_rasterizer_tb;

    localparam int WATCHDOG = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    alr_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    alr_pkg::rsp_t rsp;
    int errors, pending, points_seen, lines_done;
    int idle_cycles = 0;
    int sent = 0;
    logic stall_mode = 1'b0;

    always #10 clk = ~clk;

    angle_guided_line_rasterizer dut (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_stall(req_stall),
        .req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    alr_checker #(.FRAC(8)) chk (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_stall(req_stall),
        .req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .errors(errors), .pending(pending), .points_seen(points_seen),
        .lines_done(lines_done)
    );

    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
        rsp_stall <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b0;
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            idle_cycles <= 0;
        end
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("angle_guided_line_rasterizer regression: fail");
                $finish;
            end
        end
    end

    task automatic send_request(input alr_pkg::op_t op, input alr_pkg::coord_t sx,
                                input alr_pkg::coord_t sy, input alr_pkg::coord_t ex,
                                input alr_pkg::coord_t ey);
        @(negedge clk);
        req_valid <= 1'b1;
        req <= '{op, sx, sy, ex, ey};
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sent++;
        @(negedge clk);
        if ($urandom_range(0, 2) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic draw_line(input alr_pkg::coord_t sx, input alr_pkg::coord_t sy,
                             input alr_pkg::coord_t ex, input alr_pkg::coord_t ey,
                             input int steps);
        send_request(alr_pkg::OP_START, sx, sy, ex, ey);
        for (int i = 0; i < steps; i++)
            send_request(alr_pkg::OP_ADVANCE, alr_pkg::coord_t'($urandom),
                         alr_pkg::coord_t'($urandom), alr_pkg::coord_t'($urandom),
                         alr_pkg::coord_t'($urandom));
    endtask

    function automatic alr_pkg::coord_t near_coord(input alr_pkg::coord_t c);
        return alr_pkg::coord_t'(c + $signed($urandom_range(0, 24)) - 12);
    endfunction

    initial
    begin
        alr_pkg::coord_t sx, sy, ex, ey;
        int n;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_request(alr_pkg::OP_ADVANCE, 12'sd5, 12'sd5, 12'sd5, 12'sd5);
        draw_line(12'sd3, -12'sd4, 12'sd3, -12'sd4, 1);
        draw_line(-12'sd2048, -12'sd2048, -12'sd2044, -12'sd2046, 6);
        draw_line(12'sd2047, 12'sd0, -12'sd2048, 12'sd1, 2);
        draw_line(12'sd0, 12'sd0, 12'sd3, -12'sd1, 4);
        draw_line(12'sd2047, 12'sd2047, 12'sd2044, 12'sd2046, 5);
        draw_line(12'sd0, 12'sd0, 12'sd0, -12'sd2, 3);
        draw_line(-12'sd1, 12'sd0, 12'sd1, 12'sd0, 1);
        req_valid <= 1'b0;
        wait (pending == 0);
        repeat (60) @(negedge clk);
        while (sent < 545)
        begin
            n = $urandom_range(0, 9);
            if (n == 0)
            begin
                send_request(alr_pkg::op_t'($urandom_range(0, 1)),
                             alr_pkg::coord_t'($urandom), alr_pkg::coord_t'($urandom),
                             alr_pkg::coord_t'($urandom), alr_pkg::coord_t'($urandom));
            end
            else
            begin
                sx = alr_pkg::coord_t'($urandom);
                sy = alr_pkg::coord_t'($urandom);
                ex = n < 3 ? alr_pkg::coord_t'($urandom) : near_coord(sx);
                ey = n < 3 ? alr_pkg::coord_t'($urandom) : near_coord(sy);
                draw_line(sx, sy, ex, ey, $urandom_range(1, 16));
            end
        end
        @(negedge clk);
        req_valid <= 1'b0;
        wait (pending == 0);
        repeat (100) @(posedge clk);
        $display("Sent %0d requests; %0d points checked, %0d of them line ends.",
                 sent, points_seen, lines_done);
        if (errors == 0)
            $display("angle_guided_line_rasterizer regression: pass");
        else
            $display("angle_guided_line_rasterizer regression: fail");
        $finish;
    end

endmodule
